>>> hdl/fcce_pkg.sv
// Shared types and constants for the cluster chain engine.
// No dependencies; imported by every module of the block.
package fcce_pkg;

	localparam int unsigned ENTRY_W = 28;
	localparam int unsigned CL_W    = 12;
	localparam int unsigned CNT_W   = 13;

	localparam logic [ENTRY_W-1:0] END_MARK  = 28'hFFFFFFF;
	localparam logic [ENTRY_W-1:0] END_MIN   = 28'hFFFFFF8;
	localparam logic [ENTRY_W-1:0] FREE_MARK = 28'h0000000;

	localparam logic [CNT_W-1:0] CLUSTER_COUNT_RST = 13'd4096;
	localparam logic [CNT_W-1:0] FIRST_CLUSTER     = 13'd2;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_ALLOC = 2'd1,
		REQ_FREE  = 2'd2,
		REQ_LOAD  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} stat_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_WAIT,
		ST_SCAN,
		ST_MARK,
		ST_LINK,
		ST_FREE_RD,
		ST_FREE_CHK
	} state_t;

	typedef struct packed {
		logic               fire;
		stat_t              status;
		logic [ENTRY_W-1:0] value;
		logic [CNT_W-1:0]   freed;
	} result_t;

endpackage

>>> hdl/fcce_mem.sv
// Allocation table storage: one write port, one read port, registered read data.
// Depends on fcce_pkg for the entry width.
module fcce_mem #(
	parameter int unsigned FAT_DEPTH = 4096,
	parameter int unsigned AW        = 12
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [fcce_pkg::ENTRY_W-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [fcce_pkg::ENTRY_W-1:0] wr_data
);
	import fcce_pkg::*;

	logic [ENTRY_W-1:0] mem_q [FAT_DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/fcce_ctrl.sv
// Request sequencer: clearing pass, link read, free-entry scan, chain free, raw load.
// Depends on fcce_pkg; drives the table memory ports of fcce_mem.
module fcce_ctrl #(
	parameter int unsigned FAT_DEPTH = 4096,
	parameter int unsigned AW        = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  fcce_pkg::req_t               req_type,
	input  logic [fcce_pkg::CL_W-1:0]    cluster,
	input  logic [fcce_pkg::ENTRY_W-1:0] load_value,
	input  logic [fcce_pkg::CNT_W-1:0]   lim,
	output logic                         rd_en,
	output logic [AW-1:0]                rd_addr,
	input  logic [fcce_pkg::ENTRY_W-1:0] rd_data,
	output logic                         wr_en,
	output logic [AW-1:0]                wr_addr,
	output logic [fcce_pkg::ENTRY_W-1:0] wr_data,
	output fcce_pkg::result_t            result
);
	import fcce_pkg::*;

	localparam logic [AW-1:0] LAST_ADDR = AW'(FAT_DEPTH - 1);

	state_t             state_q, state_d;
	logic [CL_W-1:0]    cl_q, cl_d;
	logic [ENTRY_W-1:0] cur_q, cur_d;
	logic [CNT_W-1:0]   steps_q, steps_d;
	logic [CNT_W-1:0]   freed_q, freed_d;
	logic [CNT_W-1:0]   issue_q, issue_d;
	logic [CNT_W-1:0]   chk_q, chk_d;
	logic               chk_vld_q, chk_vld_d;
	logic [CNT_W-1:0]   found_q, found_d;
	logic [AW-1:0]      clr_q, clr_d;
	result_t            res_q, res_d;

	logic [CNT_W-1:0]   cl_ext;
	logic [CNT_W-1:0]   freed_inc;

	assign cl_ext    = CNT_W'(cluster);
	assign freed_inc = freed_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			chk_vld_q <= 1'b0;
			res_q     <= '0;
		end else begin
			state_q   <= state_d;
			clr_q     <= clr_d;
			chk_vld_q <= chk_vld_d;
			res_q     <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		cl_q    <= cl_d;
		cur_q   <= cur_d;
		steps_q <= steps_d;
		freed_q <= freed_d;
		issue_q <= issue_d;
		chk_q   <= chk_d;
		found_q <= found_d;
	end

	always_comb begin
		state_d   = state_q;
		cl_d      = cl_q;
		cur_d     = cur_q;
		steps_d   = steps_q;
		freed_d   = freed_q;
		issue_d   = issue_q;
		chk_d     = chk_q;
		chk_vld_d = 1'b0;
		found_d   = found_q;
		clr_d     = clr_q;
		res_d     = '0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = FREE_MARK;

		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				clr_d   = clr_q + AW'(1);
				if (clr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cl_d = cluster;
					case (req_type)
						REQ_READ: begin
							if (cl_ext < lim) begin
								rd_en   = 1'b1;
								rd_addr = AW'(cluster);
								state_d = ST_RD_WAIT;
							end else begin
								res_d.fire   = 1'b1;
								res_d.status = STAT_RANGE;
							end
						end
						REQ_ALLOC: begin
							if (cluster != '0 && cl_ext >= lim) begin
								res_d.fire   = 1'b1;
								res_d.status = STAT_RANGE;
							end else if (lim <= FIRST_CLUSTER) begin
								res_d.fire   = 1'b1;
								res_d.status = STAT_FULL;
							end else begin
								issue_d = FIRST_CLUSTER;
								state_d = ST_SCAN;
							end
						end
						REQ_FREE: begin
							cur_d   = ENTRY_W'(cluster);
							steps_d = '0;
							freed_d = '0;
							state_d = ST_FREE_RD;
						end
						REQ_LOAD: begin
							res_d.fire = 1'b1;
							if (cl_ext < lim) begin
								wr_en        = 1'b1;
								wr_addr      = AW'(cluster);
								wr_data      = load_value;
								res_d.status = STAT_OK;
							end else begin
								res_d.status = STAT_RANGE;
							end
						end
						default: begin
							res_d.fire   = 1'b1;
							res_d.status = STAT_RANGE;
						end
					endcase
				end
			end
			ST_RD_WAIT: begin
				res_d.fire   = 1'b1;
				res_d.status = STAT_OK;
				res_d.value  = rd_data;
				state_d      = ST_IDLE;
			end
			ST_SCAN: begin
				// one read issued per cycle; the entry read last cycle is checked now
				if (chk_vld_q && rd_data == FREE_MARK) begin
					found_d = chk_q;
					state_d = ST_MARK;
				end else if (issue_q < lim) begin
					rd_en     = 1'b1;
					rd_addr   = AW'(issue_q);
					chk_d     = issue_q;
					chk_vld_d = 1'b1;
					issue_d   = issue_q + CNT_W'(1);
				end else if (!chk_vld_q) begin
					res_d.fire   = 1'b1;
					res_d.status = STAT_FULL;
					state_d      = ST_IDLE;
				end
			end
			ST_MARK: begin
				wr_en   = 1'b1;
				wr_addr = AW'(found_q);
				wr_data = END_MARK;
				if (cl_q != '0) begin
					state_d = ST_LINK;
				end else begin
					res_d.fire   = 1'b1;
					res_d.status = STAT_OK;
					res_d.value  = ENTRY_W'(found_q);
					state_d      = ST_IDLE;
				end
			end
			ST_LINK: begin
				// overwrites the end mark when the last cluster is the found one
				wr_en        = 1'b1;
				wr_addr      = AW'(cl_q);
				wr_data      = ENTRY_W'(found_q);
				res_d.fire   = 1'b1;
				res_d.status = STAT_OK;
				res_d.value  = ENTRY_W'(found_q);
				state_d      = ST_IDLE;
			end
			ST_FREE_RD: begin
				if (steps_q >= lim || cur_q < ENTRY_W'(FIRST_CLUSTER)
						|| cur_q >= ENTRY_W'(lim)) begin
					res_d.fire   = 1'b1;
					res_d.status = STAT_RANGE;
					res_d.freed  = freed_q;
					state_d      = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(cur_q);
					state_d = ST_FREE_CHK;
				end
			end
			ST_FREE_CHK: begin
				if (rd_data == FREE_MARK) begin
					res_d.fire   = 1'b1;
					res_d.status = STAT_RANGE;
					res_d.freed  = freed_q;
					state_d      = ST_IDLE;
				end else begin
					wr_en   = 1'b1;
					wr_addr = AW'(cur_q);
					wr_data = FREE_MARK;
					freed_d = freed_inc;
					if (rd_data >= END_MIN) begin
						res_d.fire   = 1'b1;
						res_d.status = STAT_OK;
						res_d.freed  = freed_inc;
						state_d      = ST_IDLE;
					end else begin
						cur_d   = rd_data;
						steps_d = steps_q + CNT_W'(1);
						state_d = ST_FREE_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign result = res_q;

endmodule

>>> hdl/fat_cluster_chain_engine_unit.sv
// Top level of the cluster chain engine: configuration register, sequencer, table memory.
// Depends on fcce_pkg, fcce_ctrl and fcce_mem.
//
// After reset the block sweeps the whole table to zero, one entry per cycle, and holds busy high
// while it does. A request is taken when start is high and busy is low; its single result
// appears for one cycle with done high and must be captured then. All time is spent on the one
// table read port: a link read reads one entry, a load writes one, an allocate scans from cluster
// 2 upward, marks the first free entry as a chain end and links a nonzero cluster to it (full when
// none is free), and a chain free reads and clears each entry until the end or a broken chain.
// busy drops in the cycle done is shown, so the next request may start then; the user must ensure
// cluster_count is written via cfg_valid/cfg_data only while idle; the block does not enforce it.
module fat_cluster_chain_engine_unit #(
	parameter int unsigned FAT_DEPTH = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   req_type,
	input  logic [fcce_pkg::CL_W-1:0]    cluster,
	input  logic [fcce_pkg::ENTRY_W-1:0] load_value,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [fcce_pkg::ENTRY_W-1:0] value,
	output logic [fcce_pkg::CNT_W-1:0]   freed_count,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [fcce_pkg::CNT_W-1:0]   cfg_data
);
	import fcce_pkg::*;

	localparam int unsigned AW        = $clog2(FAT_DEPTH);
	localparam int unsigned CNT_MAX   = (1 << CNT_W) - 1;
	localparam int unsigned DEPTH_CAP = (FAT_DEPTH > CNT_MAX) ? CNT_MAX : FAT_DEPTH;

	logic [CNT_W-1:0]   cluster_count_q;
	logic [CNT_W-1:0]   lim;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	result_t            result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= CLUSTER_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			cluster_count_q <= cfg_data;
		end
	end

	// clamp the active limit to the table depth
	assign lim = (cluster_count_q > CNT_W'(DEPTH_CAP)) ? CNT_W'(DEPTH_CAP) : cluster_count_q;

	fcce_ctrl #(
		.FAT_DEPTH(FAT_DEPTH),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_t'(req_type)),
		.cluster   (cluster),
		.load_value(load_value),
		.lim       (lim),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.result    (result)
	);

	fcce_mem #(
		.FAT_DEPTH(FAT_DEPTH),
		.AW       (AW)
	) u_mem (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	assign done        = result.fire;
	assign status      = result.status;
	assign value       = result.value;
	assign freed_count = result.freed;

endmodule

>>> verif/fcce_checker.sv
// Result checker for the cluster chain engine: keeps a shadow allocation table and limit register,
// predicts the outcome of each accepted request and compares it with the result on done.
// Depends on fcce_pkg.
module fcce_checker #(
	parameter int FAT_DEPTH = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [1:0]                   req_type,
	input  logic [fcce_pkg::CL_W-1:0]    cluster,
	input  logic [fcce_pkg::ENTRY_W-1:0] load_value,
	input  logic                         done,
	input  logic [1:0]                   status,
	input  logic [fcce_pkg::ENTRY_W-1:0] value,
	input  logic [fcce_pkg::CNT_W-1:0]   freed_count,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [fcce_pkg::CNT_W-1:0]   cfg_data,
	output int                           fail_count,
	output int                           pending
);
	import fcce_pkg::*;

	typedef struct packed {
		stat_t              status;
		logic [ENTRY_W-1:0] value;
		logic [CNT_W-1:0]   freed;
	} outcome_t;

	logic [ENTRY_W-1:0] shadow [FAT_DEPTH];
	logic [CNT_W-1:0]   count_reg;
	outcome_t           outcome_q [$];

	task automatic report(input string what, input longint got, input longint want);
		// keep the log short on a badly broken block, but count everything
		if (fail_count < 100) begin
			$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		end
		fail_count++;
	endtask

	function automatic outcome_t serve_request(input req_t kind, input logic [CL_W-1:0] cl,
			input logic [ENTRY_W-1:0] ld);
		outcome_t           o;
		int                 lim;
		int                 c;
		int                 cur;
		int                 s;
		logic [ENTRY_W-1:0] e;
		bit                 stop;
		o.status = STAT_OK;
		o.value = '0;
		o.freed = '0;
		lim = (count_reg > FAT_DEPTH) ? FAT_DEPTH : int'(count_reg);
		case (kind)
			REQ_READ: begin
				if (cl < lim) o.value = shadow[cl];
				else o.status = STAT_RANGE;
			end
			REQ_ALLOC: begin
				if (cl != 0 && cl >= lim) begin
					o.status = STAT_RANGE;
				end else begin
					c = 2;
					while (c < lim && shadow[c] != FREE_MARK) c++;
					if (c >= lim) begin
						o.status = STAT_FULL;
					end else begin
						// mark first, so a self link overwrites the end mark
						shadow[c] = END_MARK;
						if (cl != 0) shadow[cl] = ENTRY_W'(c);
						o.value = ENTRY_W'(c);
					end
				end
			end
			REQ_FREE: begin
				// a walk that runs out of steps is a broken chain too
				o.status = STAT_RANGE;
				cur = int'(cl);
				stop = 0;
				for (s = 0; s < lim && !stop; s++) begin
					if (cur < 2 || cur >= lim) begin
						stop = 1;
					end else begin
						e = shadow[cur];
						if (e == FREE_MARK) begin
							stop = 1;
						end else begin
							shadow[cur] = FREE_MARK;
							o.freed = o.freed + 1'b1;
							if (e >= END_MIN) begin
								o.status = STAT_OK;
								stop = 1;
							end else begin
								cur = int'(e);
							end
						end
					end
				end
			end
			default: begin
				if (cl < lim) shadow[cl] = ld;
				else o.status = STAT_RANGE;
			end
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < FAT_DEPTH; i++) shadow[i] = FREE_MARK;
			count_reg = CLUSTER_COUNT_RST;
			outcome_q.delete();
			fail_count = 0;
		end else begin
			// retire the finished item before taking the next one on the same edge
			if (done) begin
				if (outcome_q.size() == 0) begin
					report("result with no request pending, status", status, 0);
				end else begin
					want = outcome_q.pop_front();
					if (status != want.status) report("status", status, want.status);
					if (value != want.value) report("value", value, want.value);
					if (freed_count != want.freed) report("freed_count", freed_count, want.freed);
				end
			end
			if (start && !busy) begin
				outcome_q.push_back(serve_request(req_t'(req_type), cluster, load_value));
			end
			if (cfg_valid && cfg_ready) count_reg = cfg_data;
		end
		pending = outcome_q.size();
	end

endmodule

>>> verif/tb.sv
// Testbench top for the cluster chain engine: clock, reset, request and limit-register stimulus.
// Depends on fcce_pkg, fat_cluster_chain_engine_unit and fcce_checker.
module tb;
	import fcce_pkg::*;

	localparam longint unsigned RUN_LIMIT = 64'd60_000_000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         req_type = REQ_READ;
	logic [CL_W-1:0]    cluster = '0;
	logic [ENTRY_W-1:0] load_value = '0;
	logic               cfg_valid = 1'b0;
	logic [CNT_W-1:0]   cfg_data = '0;
	logic               busy;
	logic               done;
	logic               cfg_ready;
	logic [1:0]         status;
	logic [ENTRY_W-1:0] value;
	logic [CNT_W-1:0]   freed_count;
	int                 fail_count;
	int                 pending;

	bit                 quiet;
	bit                 full_seen;
	int                 heads [$];
	int                 tails [$];

	fat_cluster_chain_engine_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .cluster(cluster), .load_value(load_value),
		.done(done), .status(status), .value(value), .freed_count(freed_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	fcce_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .cluster(cluster), .load_value(load_value),
		.done(done), .status(status), .value(value), .freed_count(freed_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_cluster(input int lim);
		if ($urandom_range(0, 99) < 15) return $urandom_range(0, 4095);
		return $urandom_range(0, lim - 1);
	endfunction

	function automatic logic [ENTRY_W-1:0] pick_entry(input int lim);
		logic [ENTRY_W-1:0] v;
		v = ENTRY_W'($urandom);
		case ($urandom_range(0, 7))
			0: v = FREE_MARK;
			1: v = END_MARK;
			2: v = END_MIN + ENTRY_W'($urandom_range(0, 7));
			3: v = END_MIN - 1'b1;
			4, 5: v = ENTRY_W'($urandom_range(0, lim - 1));
			6: v = ENTRY_W'($urandom_range(0, 1));
			default: ;
		endcase
		return v;
	endfunction

	// drop start and scramble the fields while pausing
	task automatic pause(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			cluster <= CL_W'($urandom);
			load_value <= ENTRY_W'($urandom);
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic issue(input req_t kind, input int cl, input logic [ENTRY_W-1:0] ld,
			input bit want, output logic [1:0] st, output logic [ENTRY_W-1:0] val);
		st = STAT_OK;
		val = '0;
		@(negedge clk);
		start <= 1'b1;
		req_type <= kind;
		cluster <= CL_W'(cl);
		load_value <= ld;
		do @(posedge clk); while (busy);
		if (want) begin
			@(negedge clk);
			start <= 1'b0;
			do @(posedge clk); while (!done);
			st = status;
			val = value;
		end
	endtask

	task automatic go(input req_t kind, input int cl, input logic [ENTRY_W-1:0] ld);
		logic [1:0]         st;
		logic [ENTRY_W-1:0] val;
		issue(kind, cl, ld, 1'b0, st, val);
		pause(pick_gap());
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] cnt);
		wait_drained();
		repeat (2) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cnt;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data <= CNT_W'($urandom);
	endtask

	// mostly chain building and freeing, with reads, loads and noise mixed in
	task automatic random_item(input int lim);
		int                 r;
		int                 k;
		int                 cl;
		bit                 fresh;
		logic [1:0]         st;
		logic [ENTRY_W-1:0] val;
		r = $urandom_range(0, 99);
		if (full_seen && heads.size() > 0) r = 40;
		if (r < 35) begin
			fresh = heads.size() == 0 || (heads.size() < 8 && $urandom_range(0, 9) < 3);
			k = fresh ? 0 : $urandom_range(0, heads.size() - 1);
			cl = fresh ? 0 : tails[k];
			if ($urandom_range(0, 19) == 0) cl = pick_cluster(lim);
			issue(REQ_ALLOC, cl, ENTRY_W'($urandom), 1'b1, st, val);
			full_seen = st == STAT_FULL;
			if (st == STAT_OK && fresh && cl == 0) begin
				heads.push_back(int'(val));
				tails.push_back(int'(val));
			end else if (st == STAT_OK && !fresh && cl == tails[k]) begin
				tails[k] = int'(val);
			end
		end else if (r < 50) begin
			if (heads.size() > 0) begin
				k = $urandom_range(0, heads.size() - 1);
				cl = heads[k];
				heads.delete(k);
				tails.delete(k);
			end else begin
				cl = pick_cluster(lim);
			end
			full_seen = 0;
			issue(REQ_FREE, cl, ENTRY_W'($urandom), 1'b0, st, val);
		end else if (r < 65) begin
			cl = pick_cluster(lim);
			if (heads.size() > 0 && $urandom_range(0, 1)) begin
				k = $urandom_range(0, heads.size() - 1);
				cl = $urandom_range(0, 1) ? heads[k] : tails[k];
			end
			issue(REQ_READ, cl, ENTRY_W'($urandom), 1'b0, st, val);
		end else if (r < 78) begin
			issue(REQ_LOAD, pick_cluster(lim), pick_entry(lim), 1'b0, st, val);
		end else begin
			issue(req_t'($urandom_range(0, 3)), $urandom_range(0, 4095), ENTRY_W'($urandom),
				1'b0, st, val);
		end
		if ($urandom_range(0, 99) < 3) wait_drained();
		else pause(pick_gap());
	endtask

	initial begin
		int cnt;
		int items;
		int c;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// table edges, a short chain, and every way a free walk can stop
		quiet = 0;
		go(REQ_READ, 0, '0);
		go(REQ_READ, 4095, '0);
		go(REQ_LOAD, 4095, 28'hFFFFFFF);
		go(REQ_READ, 4095, '0);
		go(REQ_LOAD, 5, 28'h5A5A5A5);
		go(REQ_ALLOC, 0, '0);
		go(REQ_ALLOC, 2, '0);
		go(REQ_ALLOC, 3, '0);
		go(REQ_READ, 2, '0);
		go(REQ_FREE, 2, '0);
		go(REQ_FREE, 0, '0);
		go(REQ_FREE, 1, '0);
		go(REQ_FREE, 2, '0);
		go(REQ_ALLOC, 2, '0);
		go(REQ_FREE, 2, '0);
		go(REQ_LOAD, 10, END_MIN - 1'b1);
		go(REQ_FREE, 10, '0);
		go(REQ_LOAD, 11, 28'd1);
		go(REQ_FREE, 11, '0);
		go(REQ_LOAD, 12, END_MIN);
		go(REQ_FREE, 12, '0);

		// smallest table: only cluster 2 can be handed out
		write_count(13'd3);
		go(REQ_READ, 3, '0);
		go(REQ_LOAD, 3, END_MARK);
		go(REQ_ALLOC, 0, '0);
		go(REQ_ALLOC, 0, '0);
		go(REQ_ALLOC, 3, '0);
		go(REQ_FREE, 2, '0);

		for (int p = 0; p < 13; p++) begin
			case (p)
				0: cnt = 3;
				3, 10: cnt = 4096;
				6: cnt = 4095;
				default: cnt = $urandom_range(4, 48);
			endcase
			items = (cnt > 1000) ? 40 : 140;
			write_count(CNT_W'(cnt));
			quiet = $urandom_range(0, 2) == 0;
			// clear the live range so allocation has room again
			if (cnt <= 1000) begin
				for (c = 2; c < cnt; c++) go(REQ_LOAD, c, FREE_MARK);
			end
			heads.delete();
			tails.delete();
			full_seen = 0;
			repeat (items) random_item(cnt > 4096 ? 4096 : cnt);
		end

		wait_drained();
		repeat (16) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
